FILE: sv/pfmt_pkg.sv
`timescale 1ns / 1ps
// package for the printf conversion formatter
// state encoding, character codes, reciprocal constant and hex digit lookup
package pfmt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_PRE,
    ST_DIG,
    ST_TAIL
  } pfmt_state_t;

  typedef logic [3:0] digit_t;

  localparam int NDIG = 10;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LESS10 = 8'h57;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;

  localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [30:0] COUNT_MAX = 31'h7FFFFFFF;

  function automatic logic [7:0] hex_char(input digit_t d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0000, d};
    end
    return CH_A_LESS10 + {4'b0000, d};
  endfunction

endpackage

FILE: sv/pfmt_div10.sv
`timescale 1ns / 1ps
// divide-by-ten unit: registered reciprocal multiply, then quotient and remainder
// depends on pfmt_pkg for the reciprocal constant
module pfmt_div10 import pfmt_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] dividend,
  output logic [31:0] quot,
  output logic [3:0]  rem
);

  logic [63:0] prod;
  logic [31:0] held;
  logic [31:0] q10;
  logic [31:0] diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {32'd0, dividend} * {32'd0, RECIP10};
      held <= dividend;
    end
  end

  always_comb begin
    quot = {{RECIP_SHIFT - 32{1'b0}}, prod[63:RECIP_SHIFT]};
    q10  = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    diff = held - q10;
    rem  = diff[3:0];
  end

endmodule

FILE: sv/printf_conversion_formatter_core.sv
`timescale 1ns / 1ps
// printf conversion formatter top level: format byte stream in, character stream out
// depends on pfmt_pkg and pfmt_div10
//
// channel   dir  tdata                                   tuser  tlast
// s_axis    in   [7:0] fmt_byte, [39:8] arg_value        -      -
// m_axis    out  [7:0] out_byte, [38:8] total_bytes      -      last
//
// one output transfer per cycle at best; a plain byte passes the idle and prefix states
// an unknown specifier emits '%' and then itself from the tail state; hex emits its digits
// a decimal conversion runs each digit through the divide-by-ten unit (multiply state,
// then remainder state), then emits the sign and up to ten digits
// s_axis_tready is high only while the sequencer is idle
// a stalled m_axis holds the output register and the sequencer waits on it
// rst clears the pending flag, the byte count and the output valid
module printf_conversion_formatter_core import pfmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] fmt_byte, [39:8] arg_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [38:8] total_bytes, [39] zero
  output logic        m_axis_tlast
);

  pfmt_state_t state, state_next;

  logic        pending;
  logic        pre_valid;
  logic [7:0]  pre_byte;
  logic        tail_valid;
  logic [7:0]  tail_byte;
  logic [3:0]  nd;
  logic [31:0] mag;
  digit_t      dig_buf [NDIG];

  logic        m_valid;
  logic [7:0]  m_byte;
  logic        m_last;
  logic [30:0] m_count;

  logic [7:0]  fmt;
  logic [31:0] arg;
  logic        acc;
  logic        out_free;
  logic        emit_go;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [3:0]  dig_rd;
  logic [3:0]  hex_cnt;
  logic        div_load;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic        dec_done;

  pfmt_div10 u_div10 (
    .clk      (clk),
    .load     (div_load),
    .dividend (mag),
    .quot     (quot),
    .rem      (rem)
  );

  assign fmt      = s_axis_tdata[7:0];
  assign arg      = s_axis_tdata[39:8];
  assign out_free = !m_valid || m_axis_tready;
  assign dig_rd   = nd - 4'd1;
  assign dec_done = (quot == 32'd0) || (nd == 4'(NDIG - 1));

  always_comb begin
    hex_cnt = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (arg[4*i +: 4] != 4'd0) begin
        hex_cnt = 4'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && fmt != CH_NUL) begin
          if (pending && fmt == CH_D) begin
            state_next = ST_MUL;
          end else if (pending || fmt != CH_PERCENT) begin
            state_next = ST_PRE;
          end
        end
      end
      ST_MUL: state_next = ST_REM;
      ST_REM: begin
        if (dec_done) begin
          state_next = ST_PRE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_PRE: begin
        if (!pre_valid || out_free) begin
          if (nd != 4'd0) begin
            state_next = ST_DIG;
          end else if (tail_valid) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIG: begin
        if (nd == 4'd0 || (nd == 4'd1 && out_free)) begin
          state_next = tail_valid ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (!tail_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_load      = 1'b0;
    emit_go       = 1'b0;
    emit_byte     = pre_byte;
    emit_last     = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL:  div_load = 1'b1;
      ST_REM:  ;
      ST_PRE: begin
        emit_go   = pre_valid && out_free;
        emit_byte = pre_byte;
        emit_last = (nd == 4'd0) && !tail_valid;
      end
      ST_DIG: begin
        emit_go   = (nd != 4'd0) && out_free;
        emit_byte = hex_char(dig_buf[dig_rd]);
        emit_last = (nd == 4'd1) && !tail_valid;
      end
      ST_TAIL: begin
        emit_go   = tail_valid && out_free;
        emit_byte = tail_byte;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        if (fmt == CH_NUL) begin
          pending <= 1'b0;
        end else if (!pending) begin
          pending <= (fmt == CH_PERCENT);
        end else begin
          pending <= 1'b0;
        end
      end
    end
  end

  // item setup and digit generation
  always_ff @(posedge clk) begin
    if (acc) begin
      pre_valid  <= 1'b1;
      pre_byte   <= fmt;
      tail_valid <= 1'b0;
      tail_byte  <= fmt;
      nd         <= 4'd0;
      mag        <= arg[31] ? (32'd0 - arg) : arg;
      if (pending) begin
        case (fmt)
          CH_C: pre_byte <= arg[7:0];
          CH_D: begin
            pre_valid <= arg[31];
            pre_byte  <= CH_MINUS;
          end
          CH_X: begin
            pre_valid <= 1'b0;
            nd        <= hex_cnt;
            for (int i = 0; i < 8; i++) begin
              dig_buf[i] <= arg[4*i +: 4];
            end
          end
          CH_PERCENT: pre_byte <= CH_PERCENT;
          default: begin
            pre_byte   <= CH_PERCENT;
            tail_valid <= 1'b1;
          end
        endcase
      end
    end else if (state == ST_REM) begin
      dig_buf[nd] <= rem;
      nd          <= nd + 4'd1;
      mag         <= quot;
    end else if (state == ST_DIG && emit_go) begin
      nd <= nd - 4'd1;
    end
  end

  // output register with running count
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      m_count <= 31'd0;
    end else if (emit_go) begin
      m_valid <= 1'b1;
      if (m_count != COUNT_MAX) begin
        m_count <= m_count + 31'd1;
      end
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_byte <= emit_byte;
      m_last <= emit_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {1'b0, m_count, m_byte};
  assign m_axis_tlast  = m_last;

endmodule
